// File: rtl/lpfd_pkg.sv
// ----------------------------------------------------------------------------
// lpfd_pkg: shared types and constants for the frame deframer
// Beat structures for the input and result channels and the positions of
// the eight header bytes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lpfd_pkg;

  // Header byte positions: four opcode bytes, then four length bytes, LSB first.
  localparam logic [2:0] HDR_OPC_B0 = 3'd0;
  localparam logic [2:0] HDR_OPC_B1 = 3'd1;
  localparam logic [2:0] HDR_OPC_B2 = 3'd2;
  localparam logic [2:0] HDR_OPC_B3 = 3'd3;
  localparam logic [2:0] HDR_LEN_B0 = 3'd4;
  localparam logic [2:0] HDR_LEN_B1 = 3'd5;
  localparam logic [2:0] HDR_LEN_B2 = 3'd6;
  localparam logic [2:0] HDR_LEN_B3 = 3'd7;

  // One received beat.
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       link_reset;
  } in_beat_t;

  // One result beat.
  typedef struct packed {
    logic [7:0]  payload_byte;
    logic [31:0] frame_opcode;
    logic [31:0] frame_length;
    logic        first_of_frame;
    logic        last_of_frame;
    logic        empty_frame;
  } out_beat_t;

endpackage

`default_nettype wire

// File: rtl/lpfd_if.sv
// ----------------------------------------------------------------------------
// lpfd_if: valid/ready channels of the frame deframer
// lpfd_in_if carries received bytes, lpfd_out_if carries payload results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface lpfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       link_reset;

  modport source (output valid, output rx_byte, output link_reset, input ready);
  modport sink   (input valid, input rx_byte, input link_reset, output ready);
endinterface

interface lpfd_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  payload_byte;
  logic [31:0] frame_opcode;
  logic [31:0] frame_length;
  logic        first_of_frame;
  logic        last_of_frame;
  logic        empty_frame;

  modport source (output valid, output payload_byte, output frame_opcode,
                  output frame_length, output first_of_frame,
                  output last_of_frame, output empty_frame, input ready);
  modport sink   (input valid, input payload_byte, input frame_opcode,
                  input frame_length, input first_of_frame,
                  input last_of_frame, input empty_frame, output ready);
endinterface

`default_nettype wire

// File: rtl/length_prefixed_frame_deframer.sv
// ----------------------------------------------------------------------------
// length_prefixed_frame_deframer: byte-stream deframer with 8-byte header
// Path: an accepted byte passes the input register, then the result register.
// Throughput: one byte per cycle unless the result side stalls.
// Header bytes and link resets yield no result except the empty-frame marker.
// Reset: synchronous active-low rst_n empties both registers and returns the
// frame state to header collection.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module length_prefixed_frame_deframer (
  input  wire logic   clk,
  input  wire logic   rst_n,
  lpfd_in_if.sink     in_ch,
  lpfd_out_if.source  out_ch
);
  import lpfd_pkg::*;

  in_beat_t  in_beat;
  in_beat_t  s1_beat;
  out_beat_t res_beat;
  out_beat_t out_beat;
  logic      s1_valid;
  logic      s1_take;
  logic      res_valid;
  logic      out_can_take;

  assign in_beat.rx_byte    = in_ch.rx_byte;
  assign in_beat.link_reset = in_ch.link_reset;

  // Input register.
  lpfd_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_beat  (in_beat),
    .s1_valid (s1_valid),
    .s1_beat  (s1_beat),
    .s1_take  (s1_take)
  );

  // Header assembly and payload tagging.
  lpfd_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .s1_valid     (s1_valid),
    .s1_beat      (s1_beat),
    .s1_take      (s1_take),
    .out_can_take (out_can_take),
    .res_valid    (res_valid),
    .res_beat     (res_beat)
  );

  // Result register.
  lpfd_out_stage u_out_stage (
    .clk          (clk),
    .rst_n        (rst_n),
    .res_valid    (res_valid),
    .res_beat     (res_beat),
    .out_can_take (out_can_take),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .out_beat     (out_beat)
  );

  assign out_ch.payload_byte   = out_beat.payload_byte;
  assign out_ch.frame_opcode   = out_beat.frame_opcode;
  assign out_ch.frame_length   = out_beat.frame_length;
  assign out_ch.first_of_frame = out_beat.first_of_frame;
  assign out_ch.last_of_frame  = out_beat.last_of_frame;
  assign out_ch.empty_frame    = out_beat.empty_frame;

endmodule

`default_nettype wire

// File: rtl/lpfd_in_stage.sv
// ----------------------------------------------------------------------------
// lpfd_in_stage: input register
// Captures one received beat and holds it until the parser takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lpfd_in_stage (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire lpfd_pkg::in_beat_t in_beat,
  output logic                   s1_valid,
  output lpfd_pkg::in_beat_t     s1_beat,
  input  wire logic              s1_take
);
  import lpfd_pkg::*;

  logic     valid_r;
  in_beat_t beat_r;

  // The register is free when empty or when its beat leaves this cycle.
  assign in_ready = !valid_r || s1_take;
  assign s1_valid = valid_r;
  assign s1_beat  = beat_r;

  // Valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  // Beat payload.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      beat_r <= in_beat;
    end
  end

endmodule

`default_nettype wire

// File: rtl/lpfd_core.sv
// ----------------------------------------------------------------------------
// lpfd_core: header assembly and payload tagging
// Tracks the frame phase, collects the eight header bytes and tags each
// payload byte with opcode, length and first/last/empty flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lpfd_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               s1_valid,
  input  wire lpfd_pkg::in_beat_t s1_beat,
  output logic                    s1_take,
  input  wire logic               out_can_take,
  output logic                    res_valid,
  output lpfd_pkg::out_beat_t     res_beat
);
  import lpfd_pkg::*;

  logic [2:0]  header_count_r,    header_count_nxt;
  logic        in_payload_r,      in_payload_nxt;
  logic [31:0] held_opcode_r,     held_opcode_nxt;
  logic [31:0] held_length_r,     held_length_nxt;
  logic [31:0] bytes_remaining_r, bytes_remaining_nxt;
  logic [31:0] remaining_dec;
  logic        has_result;

  // A beat leaves the input register only when the result register has room.
  assign s1_take   = s1_valid && out_can_take;
  assign res_valid = s1_take && has_result;

  assign remaining_dec = (bytes_remaining_r != 32'd0) ? (bytes_remaining_r - 32'd1)
                                                      : bytes_remaining_r;

  // Next state and result for the beat in the input register.
  always_comb begin
    header_count_nxt    = header_count_r;
    in_payload_nxt      = in_payload_r;
    held_opcode_nxt     = held_opcode_r;
    held_length_nxt     = held_length_r;
    bytes_remaining_nxt = bytes_remaining_r;
    has_result          = 1'b0;

    res_beat.payload_byte   = s1_beat.rx_byte;
    res_beat.frame_opcode   = held_opcode_r;
    res_beat.frame_length   = held_length_r;
    res_beat.first_of_frame = (bytes_remaining_r == held_length_r);
    res_beat.last_of_frame  = (bytes_remaining_r <= 32'd1);
    res_beat.empty_frame    = 1'b0;

    if (s1_beat.link_reset) begin
      // Dropped link: discard whatever frame was in progress.
      header_count_nxt    = 3'd0;
      in_payload_nxt      = 1'b0;
      held_opcode_nxt     = 32'd0;
      held_length_nxt     = 32'd0;
      bytes_remaining_nxt = 32'd0;
    end else if (in_payload_r) begin
      // Payload byte: pass it out and count down.
      has_result          = 1'b1;
      bytes_remaining_nxt = remaining_dec;
      if (remaining_dec == 32'd0) begin
        in_payload_nxt = 1'b0;
      end
    end else begin
      // Header byte: place it at its position, little-endian.
      case (header_count_r)
        HDR_OPC_B0: begin
          held_opcode_nxt = {24'd0, s1_beat.rx_byte};
          held_length_nxt = 32'd0;
        end
        HDR_OPC_B1: held_opcode_nxt[15:8]  = s1_beat.rx_byte;
        HDR_OPC_B2: held_opcode_nxt[23:16] = s1_beat.rx_byte;
        HDR_OPC_B3: held_opcode_nxt[31:24] = s1_beat.rx_byte;
        HDR_LEN_B0: held_length_nxt = {24'd0, s1_beat.rx_byte};
        HDR_LEN_B1: held_length_nxt[15:8]  = s1_beat.rx_byte;
        HDR_LEN_B2: held_length_nxt[23:16] = s1_beat.rx_byte;
        default:    held_length_nxt[31:24] = s1_beat.rx_byte;
      endcase

      if (header_count_r != HDR_LEN_B3) begin
        header_count_nxt = header_count_r + 3'd1;
      end else begin
        // Header complete: either an empty frame result or enter the payload.
        header_count_nxt = 3'd0;
        if (held_length_nxt == 32'd0) begin
          has_result              = 1'b1;
          res_beat.payload_byte   = 8'd0;
          res_beat.frame_length   = held_length_nxt;
          res_beat.first_of_frame = 1'b1;
          res_beat.last_of_frame  = 1'b1;
          res_beat.empty_frame    = 1'b1;
        end else begin
          in_payload_nxt      = 1'b1;
          bytes_remaining_nxt = held_length_nxt;
        end
      end
    end
  end

  // Frame state registers, updated when a beat is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_count_r    <= 3'd0;
      in_payload_r      <= 1'b0;
      held_opcode_r     <= 32'd0;
      held_length_r     <= 32'd0;
      bytes_remaining_r <= 32'd0;
    end else if (s1_take) begin
      header_count_r    <= header_count_nxt;
      in_payload_r      <= in_payload_nxt;
      held_opcode_r     <= held_opcode_nxt;
      held_length_r     <= held_length_nxt;
      bytes_remaining_r <= bytes_remaining_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/lpfd_out_stage.sv
// ----------------------------------------------------------------------------
// lpfd_out_stage: result register
// Holds one result beat until the downstream side takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lpfd_out_stage (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                res_valid,
  input  wire lpfd_pkg::out_beat_t res_beat,
  output logic                     out_can_take,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output lpfd_pkg::out_beat_t      out_beat
);
  import lpfd_pkg::*;

  logic      valid_r;
  out_beat_t beat_r;

  // Room when empty or when the held beat is taken this cycle.
  assign out_can_take = !valid_r || out_ready;
  assign out_valid    = valid_r;
  assign out_beat     = beat_r;

  // Valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (out_can_take) begin
      valid_r <= res_valid;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (res_valid && out_can_take) begin
      beat_r <= res_beat;
    end
  end

endmodule

`default_nettype wire

// File: verif/length_prefixed_frame_deframer_test.sv
// ----------------------------------------------------------------------------
// length_prefixed_frame_deframer_test: self-checking bench for the deframer
// Feeds framed byte streams (well-formed frames, truncated headers, abandoned
// long frames, link resets and noise) through the valid/ready input, predicts
// every result beat in the bench and compares each output beat field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module length_prefixed_frame_deframer_test;
  import lpfd_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_BEATS  = 1200;
  localparam int HOLD_CYCLES   = 400;
  localparam int DRAIN_CYCLES  = 8;
  localparam int IDLE_PERCENT  = 31;

  logic clk = 1'b0;
  logic rst_n;

  lpfd_in_if  in_bus ();
  lpfd_out_if out_bus ();

  length_prefixed_frame_deframer u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus)
  );

  // Bench copy of the frame state.
  logic [2:0]  hdr_pos;
  bit          in_body;
  logic [31:0] cur_opcode;
  logic [31:0] cur_length;
  logic [31:0] body_left;

  out_beat_t   pending_payload [$];
  out_beat_t   oldest_payload;

  int  error_count     = 0;
  int  beats_sent      = 0;
  int  results_checked = 0;
  int  frames_done     = 0;
  int  cycle_count     = 0;
  int  holds_asked     = 0;
  int  holds_served    = 0;
  int  hold_left       = 0;
  bit  quiet_mode      = 1'b0;

  // Clock: 12 ns period.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Return the frame state to header collection.
  function automatic void clear_frame_state();
    hdr_pos    = HDR_OPC_B0;
    in_body    = 1'b0;
    cur_opcode = '0;
    cur_length = '0;
    body_left  = '0;
  endfunction

  // Advance the frame state by one accepted beat; returns 1 when a result is due.
  function automatic bit deframe_byte(input in_beat_t b, output out_beat_t r);
    r = '0;
    if (b.link_reset) begin
      clear_frame_state();
      return 1'b0;
    end
    if (in_body) begin
      r.payload_byte   = b.rx_byte;
      r.frame_opcode   = cur_opcode;
      r.frame_length   = cur_length;
      r.first_of_frame = (body_left == cur_length);
      r.last_of_frame  = (body_left <= 32'd1);
      r.empty_frame    = 1'b0;
      if (body_left != 0) body_left = body_left - 1;
      if (body_left == 0) in_body = 1'b0;
      return 1'b1;
    end
    case (hdr_pos)
      HDR_OPC_B0: begin
        cur_opcode = {24'd0, b.rx_byte};
        cur_length = '0;
      end
      HDR_OPC_B1: cur_opcode[15:8]  = b.rx_byte;
      HDR_OPC_B2: cur_opcode[23:16] = b.rx_byte;
      HDR_OPC_B3: cur_opcode[31:24] = b.rx_byte;
      HDR_LEN_B0: cur_length = {24'd0, b.rx_byte};
      HDR_LEN_B1: cur_length[15:8]  = b.rx_byte;
      HDR_LEN_B2: cur_length[23:16] = b.rx_byte;
      default:    cur_length[31:24] = b.rx_byte;
    endcase
    if (hdr_pos != HDR_LEN_B3) begin
      hdr_pos = hdr_pos + 3'd1;
      return 1'b0;
    end
    hdr_pos = HDR_OPC_B0;
    if (cur_length == 0) begin
      // A header announcing no payload yields a single empty marker beat.
      r.payload_byte   = 8'd0;
      r.frame_opcode   = cur_opcode;
      r.frame_length   = cur_length;
      r.first_of_frame = 1'b1;
      r.last_of_frame  = 1'b1;
      r.empty_frame    = 1'b1;
      return 1'b1;
    end
    in_body   = 1'b1;
    body_left = cur_length;
    return 1'b0;
  endfunction

  // Offer one beat, with random idle cycles first outside quiet mode, and wait for acceptance.
  task automatic send_beat(input logic [7:0] data, input logic lr);
    in_beat_t  beat;
    out_beat_t due;
    while (!quiet_mode && ($urandom_range(99) < IDLE_PERCENT)) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    beat.rx_byte    = data;
    beat.link_reset = lr;
    in_bus.valid      <= 1'b1;
    in_bus.rx_byte    <= data;
    in_bus.link_reset <= lr;
    do @(posedge clk); while (!in_bus.ready);
    if (deframe_byte(beat, due)) pending_payload = {pending_payload, due};
    beats_sent++;
  endtask

  task automatic send_header(input logic [31:0] opcode, input logic [31:0] length);
    for (int i = 0; i < 4; i++) send_beat(opcode[8*i +: 8], 1'b0);
    for (int i = 0; i < 4; i++) send_beat(length[8*i +: 8], 1'b0);
  endtask

  // A complete frame with random payload content.
  task automatic send_full_frame(input logic [31:0] opcode, input int length);
    send_header(opcode, 32'(length));
    for (int i = 0; i < length; i++) send_beat(8'($urandom_range(255)), 1'b0);
    frames_done++;
  endtask

  task automatic send_link_reset();
    send_beat(8'($urandom_range(255)), 1'b1);
  endtask

  // Stop offering and wait until every predicted beat has come out.
  task automatic wait_until_drained();
    in_bus.valid <= 1'b0;
    while (pending_payload.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Extremes of the header fields and each special case of the framing.
  task automatic test_directed();
    // Empty frame with an all-ones opcode.
    send_full_frame(32'hFFFF_FFFF, 0);
    // Single-byte frame: first and last on the same beat.
    send_header(32'h0000_0000, 32'd1);
    send_beat(8'hFF, 1'b0);
    frames_done++;
    // Maximum length: two payload beats, then the link drops mid-frame.
    send_header(32'hA5A5_5A5A, 32'hFFFF_FFFF);
    send_beat(8'h00, 1'b0);
    send_beat(8'h80, 1'b0);
    send_link_reset();
    // Truncated header discarded by a link reset.
    send_beat(8'h12, 1'b0);
    send_beat(8'h34, 1'b0);
    send_link_reset();
    wait_until_drained();
  endtask

  // Hold the result side off so that the block fills and stalls its input.
  task automatic test_back_pressure();
    quiet_mode = 1'b1;
    holds_asked++;
    send_full_frame($urandom, 60);
    quiet_mode = 1'b0;
    wait_until_drained();
  endtask

  // Mostly well-formed frames with random content, plus broken sequences and noise.
  task automatic test_random();
    int start;
    int kind;
    int count;
    logic [31:0] len;
    start = beats_sent;
    while (beats_sent - start < RANDOM_BEATS) begin
      // A long stretch in the middle with neither side idling.
      quiet_mode = (beats_sent - start > 400) && (beats_sent - start < 700);
      kind = $urandom_range(99);
      if (kind < 60) begin
        count = ($urandom_range(19) == 0) ? $urandom_range(13, 64) : $urandom_range(0, 12);
        send_full_frame($urandom, count);
      end else if (kind < 75) begin
        // Random 32-bit length; the frame is abandoned after up to three payload beats.
        len = $urandom;
        send_header($urandom, len);
        count = $urandom_range(0, 3);
        for (int i = 0; i < count; i++) send_beat(8'($urandom_range(255)), 1'b0);
        send_link_reset();
      end else if (kind < 85) begin
        count = $urandom_range(1, 7);
        for (int i = 0; i < count; i++) send_beat(8'($urandom_range(255)), 1'b0);
        send_link_reset();
      end else begin
        count = $urandom_range(1, 4);
        for (int i = 0; i < count; i++) begin
          send_beat(8'($urandom_range(255)), 1'($urandom_range(1)));
        end
        send_link_reset();
      end
    end
    quiet_mode = 1'b0;
    wait_until_drained();
  endtask

  task automatic check_field(input string fname, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", fname, want, got);
      error_count++;
    end
  endtask

  // Result side: compare each accepted beat with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (pending_payload.size() == 0) begin
        $error("unexpected result beat: payload_byte 0x%0h", out_bus.payload_byte);
        error_count++;
      end else begin
        oldest_payload = pending_payload.pop_front();
        check_field("payload_byte", 32'(oldest_payload.payload_byte),
                    32'(out_bus.payload_byte));
        check_field("frame_opcode", oldest_payload.frame_opcode,
                    out_bus.frame_opcode);
        check_field("frame_length", oldest_payload.frame_length,
                    out_bus.frame_length);
        check_field("first_of_frame", 32'(oldest_payload.first_of_frame),
                    32'(out_bus.first_of_frame));
        check_field("last_of_frame", 32'(oldest_payload.last_of_frame),
                    32'(out_bus.last_of_frame));
        check_field("empty_frame", 32'(oldest_payload.empty_frame),
                    32'(out_bus.empty_frame));
        results_checked++;
      end
    end
  end

  // Result-side ready: random stalls, quiet stretches and counted hold-offs.
  initial begin
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_bus.ready <= 1'b0;
        hold_left--;
      end else if (holds_served != holds_asked) begin
        holds_served++;
        hold_left = HOLD_CYCLES;
        out_bus.ready <= 1'b0;
      end else if (quiet_mode) begin
        out_bus.ready <= 1'b1;
      end else begin
        out_bus.ready <= ($urandom_range(99) >= IDLE_PERCENT);
      end
    end
  end

  // Watchdog.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("length_prefixed_frame_deframer_test NOT OK");
    $finish;
  end

  // Sequence of tests.
  initial begin
    rst_n             <= 1'b0;
    in_bus.valid      <= 1'b0;
    in_bus.rx_byte    <= 8'd0;
    in_bus.link_reset <= 1'b0;
    clear_frame_state();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_back_pressure();
    test_random();

    if (pending_payload.size() != 0) begin
      $error("%0d predicted result beats never arrived", pending_payload.size());
      error_count++;
    end
    $display("Sent %0d beats in %0d complete frames, checked %0d result beats.",
             beats_sent, frames_done, results_checked);
    $display("Covered empty, single-byte and maximum-length frames, link resets and stalls.");
    if (error_count == 0) begin
      $display("length_prefixed_frame_deframer_test OK");
    end else begin
      $display("length_prefixed_frame_deframer_test NOT OK");
    end
    $finish;
  end

endmodule
